// File: rtl/core/tlnc_pkg.sv
package tlnc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CYC_W      = 4;
    localparam int SEC_W      = 7;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] CFG_RED       = 3'd0;
    localparam logic [IDX_W-1:0] CFG_YELLOW    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GREEN     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_NIGHT     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BLINK     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_COUNTDOWN = 3'd5;
    localparam logic [IDX_W-1:0] CFG_BUTTON    = 3'd6;
    localparam logic [IDX_W-1:0] CFG_CYCLES    = 3'd7;

    localparam int RST_RED_MS       = 5000;
    localparam int RST_YELLOW_MS    = 2000;
    localparam int RST_GREEN_MS     = 4000;
    localparam int RST_NIGHT_MS     = 10000;
    localparam int RST_BLINK_MS     = 250;
    localparam int RST_COUNTDOWN_MS = 1000;
    localparam int RST_BUTTON_MS    = 50;
    localparam int RST_CYCLES       = 1;
    localparam int MS_PER_SEC       = 1000;

    localparam logic [SEC_W-1:0] RST_RED_SEC    = SEC_W'(RST_RED_MS / MS_PER_SEC);
    localparam logic [SEC_W-1:0] RST_YELLOW_SEC = SEC_W'(RST_YELLOW_MS / MS_PER_SEC);
    localparam logic [SEC_W-1:0] RST_GREEN_SEC  = SEC_W'(RST_GREEN_MS / MS_PER_SEC);

    // x / 1000 == (x >> 3) / 125, the latter by reciprocal 2^27 / 125 rounded up
    localparam int            RECIP_SHIFT = 27;
    localparam logic [20:0]   RECIP_125   = 21'd1073742;

    localparam logic [1:0] PH_RED    = 2'd0;
    localparam logic [1:0] PH_YELLOW = 2'd1;
    localparam logic [1:0] PH_GREEN  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] red_ms;
        logic [CFG_W-1:0] yellow_ms;
        logic [CFG_W-1:0] green_ms;
        logic [CFG_W-1:0] night_ms;
        logic [CFG_W-1:0] blink_ms;
        logic [CFG_W-1:0] countdown_ms;
        logic [CFG_W-1:0] button_ms;
        logic [CYC_W-1:0] cycles;
        logic [SEC_W-1:0] red_sec;
        logic [SEC_W-1:0] yellow_sec;
        logic [SEC_W-1:0] green_sec;
    } t_cfg;

    typedef struct packed {
        logic             red_on;
        logic             yellow_on;
        logic             green_on;
        logic             blue_on;
        logic             display_blank;
        logic [SEC_W-1:0] display_seconds;
    } t_result;

    function automatic logic [SEC_W-1:0] ms_to_sec(input logic [CFG_W-1:0] ms);
        logic [33:0] prod;
        prod = 34'(ms[CFG_W-1:3]) * 34'(RECIP_125);
        return prod[RECIP_SHIFT +: SEC_W];
    endfunction

endpackage

// File: rtl/core/tlnc_cfg.sv
module tlnc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tlnc_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [tlnc_pkg::CFG_W-1:0]     i_cfg_data,
    output tlnc_pkg::t_cfg                 o_cfg
);
    import tlnc_pkg::*;

    t_cfg             r_cfg;
    logic [SEC_W-1:0] n_sec;

    assign n_sec = ms_to_sec(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_ms       <= CFG_W'(RST_RED_MS);
            r_cfg.yellow_ms    <= CFG_W'(RST_YELLOW_MS);
            r_cfg.green_ms     <= CFG_W'(RST_GREEN_MS);
            r_cfg.night_ms     <= CFG_W'(RST_NIGHT_MS);
            r_cfg.blink_ms     <= CFG_W'(RST_BLINK_MS);
            r_cfg.countdown_ms <= CFG_W'(RST_COUNTDOWN_MS);
            r_cfg.button_ms    <= CFG_W'(RST_BUTTON_MS);
            r_cfg.cycles       <= CYC_W'(RST_CYCLES);
            r_cfg.red_sec      <= RST_RED_SEC;
            r_cfg.yellow_sec   <= RST_YELLOW_SEC;
            r_cfg.green_sec    <= RST_GREEN_SEC;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RED: begin
                    r_cfg.red_ms  <= i_cfg_data;
                    r_cfg.red_sec <= n_sec;
                end
                CFG_YELLOW: begin
                    r_cfg.yellow_ms  <= i_cfg_data;
                    r_cfg.yellow_sec <= n_sec;
                end
                CFG_GREEN: begin
                    r_cfg.green_ms  <= i_cfg_data;
                    r_cfg.green_sec <= n_sec;
                end
                CFG_NIGHT:     r_cfg.night_ms     <= i_cfg_data;
                CFG_BLINK:     r_cfg.blink_ms     <= i_cfg_data;
                CFG_COUNTDOWN: r_cfg.countdown_ms <= i_cfg_data;
                CFG_BUTTON:    r_cfg.button_ms    <= i_cfg_data;
                CFG_CYCLES:    r_cfg.cycles       <= i_cfg_data[CYC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/tlnc_step.sv
module tlnc_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlnc_pkg::t_cfg    i_cfg,
    input  logic              i_en,
    input  logic              i_button,
    output tlnc_pkg::t_result o_res
);
    import tlnc_pkg::*;

    typedef logic [TIMER_BITS-1:0] t_tmr;

    function automatic t_tmr sat_inc(input t_tmr t);
        return (&t) ? t : t + 1'b1;
    endfunction

    function automatic logic hit(input t_tmr t, input logic [CFG_W-1:0] p);
        return 33'(t) >= 33'(p);
    endfunction

    logic [1:0]       r_phase, n_phase;
    logic             r_night, n_night;
    t_tmr             r_pe, n_pe, r_ne, n_ne, r_ye, n_ye;
    t_tmr             r_be, n_be, r_ce, n_ce, r_ke, n_ke;
    logic             r_ybit, n_ybit, r_bbit, n_bbit;
    logic [SEC_W-1:0] r_secs, n_secs, r_shown_val, n_shown_val;
    logic             r_shown, n_shown, r_don, n_don, r_last, n_last;
    logic [CYC_W-1:0] r_cyc, n_cyc;
    logic [2:0]       r_lamp, n_lamp;
    logic             r_bpin, n_bpin;

    always_comb begin
        logic [CFG_W-1:0] ph_time;
        n_pe        = sat_inc(r_pe);
        n_ne        = sat_inc(r_ne);
        n_ye        = sat_inc(r_ye);
        n_be        = sat_inc(r_be);
        n_ce        = sat_inc(r_ce);
        n_ke        = sat_inc(r_ke);
        n_phase     = r_phase;
        n_night     = r_night;
        n_ybit      = r_ybit;
        n_bbit      = r_bbit;
        n_secs      = r_secs;
        n_shown_val = r_shown_val;
        n_shown     = r_shown;
        n_don       = r_don;
        n_last      = r_last;
        n_cyc       = r_cyc;
        n_lamp      = r_lamp;
        n_bpin      = r_bpin;

        case (r_phase)
            PH_YELLOW: ph_time = i_cfg.yellow_ms;
            PH_GREEN:  ph_time = i_cfg.green_ms;
            default:   ph_time = i_cfg.red_ms;
        endcase

        if (hit(n_ke, i_cfg.button_ms)) begin
            n_ke = '0;
            if (!i_button && r_last) begin
                n_don = ~r_don;
                if (n_don) n_bpin = 1'b0;
            end
            n_last = i_button;
        end

        if (r_night) begin
            if (hit(n_ye, i_cfg.blink_ms)) begin
                n_ye   = '0;
                n_ybit = ~r_ybit;
                n_lamp = n_ybit ? 3'b010 : 3'b000;
            end
            if (hit(n_ne, i_cfg.night_ms)) begin
                n_night = 1'b0;
                n_pe    = '0;
                n_phase = PH_RED;
                n_secs  = i_cfg.red_sec;
            end
        end else begin
            case (r_phase)
                PH_YELLOW: n_lamp = 3'b010;
                PH_GREEN:  n_lamp = 3'b100;
                default:   n_lamp = 3'b001;
            endcase
            if (hit(n_pe, ph_time)) begin
                n_pe = '0;
                case (r_phase)
                    PH_GREEN: begin
                        n_phase = PH_YELLOW;
                        n_secs  = i_cfg.yellow_sec;
                    end
                    PH_YELLOW: begin
                        n_phase = PH_RED;
                        n_secs  = i_cfg.red_sec;
                        n_cyc   = r_cyc + 1'b1;
                        if (n_cyc >= i_cfg.cycles) begin
                            n_night = 1'b1;
                            n_ne    = '0;
                            n_cyc   = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_GREEN;
                        n_secs  = i_cfg.green_sec;
                    end
                endcase
            end
        end

        if (!n_don) begin
            if (hit(n_be, i_cfg.blink_ms)) begin
                n_be   = '0;
                n_bbit = ~r_bbit;
                n_bpin = n_bbit;
            end
        end else begin
            n_bpin = 1'b0;
        end

        if (!n_don || n_night) begin
            n_shown = 1'b0;
        end else if (hit(n_ce, i_cfg.countdown_ms)) begin
            n_ce        = '0;
            n_secs      = (n_secs != '0) ? n_secs - 1'b1 : n_secs;
            n_shown_val = n_secs;
            n_shown     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RED;
            r_night     <= 1'b0;
            r_pe        <= '0;
            r_ne        <= '0;
            r_ye        <= '0;
            r_be        <= '0;
            r_ce        <= '0;
            r_ke        <= '0;
            r_ybit      <= 1'b0;
            r_bbit      <= 1'b0;
            r_secs      <= RST_RED_SEC;
            r_shown_val <= '0;
            r_shown     <= 1'b0;
            r_don       <= 1'b1;
            r_last      <= 1'b1;
            r_cyc       <= '0;
            r_lamp      <= '0;
            r_bpin      <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_night     <= n_night;
            r_pe        <= n_pe;
            r_ne        <= n_ne;
            r_ye        <= n_ye;
            r_be        <= n_be;
            r_ce        <= n_ce;
            r_ke        <= n_ke;
            r_ybit      <= n_ybit;
            r_bbit      <= n_bbit;
            r_secs      <= n_secs;
            r_shown_val <= n_shown_val;
            r_shown     <= n_shown;
            r_don       <= n_don;
            r_last      <= n_last;
            r_cyc       <= n_cyc;
            r_lamp      <= n_lamp;
            r_bpin      <= n_bpin;
        end
    end

    always_comb begin
        o_res.red_on          = n_lamp[0];
        o_res.yellow_on       = n_lamp[1];
        o_res.green_on        = n_lamp[2];
        o_res.blue_on         = n_bpin;
        o_res.display_blank   = ~n_shown;
        o_res.display_seconds = n_shown ? n_shown_val : '0;
    end

endmodule

// File: rtl/core/traffic_light_night_cycle_controller.sv
// channel  valid         stall         payload
// in       i_in_valid    o_in_stall    i_button_level
// out      o_out_valid   i_out_stall   o_red_on .. o_display_seconds
//
// One word per cycle sustained while the output is not stalled; a taken word
// passes through the input register, then the result register.
// The per-tick update is one pass of counter compares feeding the result register.
// Reset is synchronous, active low; no clearing pass.
// A stalled result holds the result register; the input stalls only when
// the input register is full and the result register is held by a stall.
module traffic_light_night_cycle_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_button_level,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_red_on,
    output logic                               o_yellow_on,
    output logic                               o_green_on,
    output logic                               o_blue_on,
    output logic                               o_display_blank,
    output logic [tlnc_pkg::SEC_W-1:0]         o_display_seconds,
    input  logic                               i_cfg_we,
    input  logic [tlnc_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [tlnc_pkg::CFG_W-1:0]         i_cfg_data
);
    import tlnc_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_out;
    logic    r_s1_valid, r_s1_button, r_out_valid;
    logic    out_full, advance;

    tlnc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tlnc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_en     (advance),
        .i_button (r_s1_button),
        .o_res    (res)
    );

    assign out_full   = r_out_valid & i_out_stall;
    assign advance    = r_s1_valid & ~out_full;
    assign o_in_stall = r_s1_valid & out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_s1_button <= i_button_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= res;
    end

    assign o_out_valid       = r_out_valid;
    assign o_red_on          = r_out.red_on;
    assign o_yellow_on       = r_out.yellow_on;
    assign o_green_on        = r_out.green_on;
    assign o_blue_on         = r_out.blue_on;
    assign o_display_blank   = r_out.display_blank;
    assign o_display_seconds = r_out.display_seconds;

endmodule

// File: rtl/core/tlnc_checker.sv
module tlnc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_red_on,
    input logic                        o_yellow_on,
    input logic                        o_green_on,
    input logic                        o_display_blank,
    input logic [tlnc_pkg::SEC_W-1:0]  o_display_seconds
);
    import tlnc_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_one_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_red_on, o_yellow_on, o_green_on}))
        else $error("more than one traffic lamp lit");

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_display_blank |-> o_display_seconds == '0)
        else $error("blank display shows a value");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_display_seconds <= SEC_W'(65))
        else $error("countdown beyond range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

endmodule

bind traffic_light_night_cycle_controller tlnc_checker u_tlnc_checker (.*);
